@@ hw/rtl/ssfr_pkg.sv @@
`timescale 1ns / 1ps

package ssfr_pkg;

  localparam int HEADER_BYTES = 4;
  localparam int MIN_LEN      = (HEADER_BYTES + 1 > 2) ? HEADER_BYTES + 1 : 2;

  localparam logic [7:0] FEND_BYTE  = 8'hC0;
  localparam logic [7:0] FESC_BYTE  = 8'hDB;
  localparam logic [7:0] TFEND_BYTE = 8'hDC;
  localparam logic [7:0] TFESC_BYTE = 8'hDD;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;

  localparam logic [2:0] GROUP_FULL = 3'd4;

  typedef struct packed {
    logic [31:0] good;
    logic [31:0] bad;
  } frame_counts_t;

  typedef enum logic [2:0] {
    UNP_IDLE,
    UNP_CNT,
    UNP_CNT_D,
    UNP_CHK,
    UNP_B0,
    UNP_B1,
    UNP_B2,
    UNP_EMIT
  } unp_state_t;

  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] data);
    logic [15:0] c;
    c = crc ^ {data, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

endpackage

@@ hw/rtl/ssfr_ram.sv @@
`timescale 1ns / 1ps

module ssfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ hw/rtl/ssfr_deframe.sv @@
`timescale 1ns / 1ps

module ssfr_deframe import ssfr_pkg::*; #(
  parameter int FRAME_BYTES = 512,
  parameter int LEN_W       = $clog2(FRAME_BYTES + 1),
  parameter int ADDR_W      = $clog2(FRAME_BYTES)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              byte_acc,
  input  logic [7:0]        rx_byte,
  output logic              wr_en,
  output logic [ADDR_W-1:0] wr_addr,
  output logic [7:0]        wr_data,
  output logic              start_r,
  output logic [LEN_W-1:0]  pay_r,
  output frame_counts_t     counts_r
);

  logic [LEN_W-1:0] len_r, len_nxt;
  logic             esc_r, esc_nxt;
  logic             drop_r, drop_nxt;
  logic [15:0]      crc_r, crc_nxt;
  logic [7:0]       p0_r, p0_nxt;
  logic [7:0]       p1_r, p1_nxt;
  logic             start_nxt;
  logic [LEN_W-1:0] pay_nxt;
  frame_counts_t    counts_nxt;
  logic [7:0]       data;

  always_comb begin
    len_nxt    = len_r;
    esc_nxt    = esc_r;
    drop_nxt   = drop_r;
    crc_nxt    = crc_r;
    p0_nxt     = p0_r;
    p1_nxt     = p1_r;
    start_nxt  = 1'b0;
    pay_nxt    = pay_r;
    counts_nxt = counts_r;
    wr_en      = 1'b0;
    wr_addr    = len_r[ADDR_W-1:0];
    data       = rx_byte;
    if (esc_r && rx_byte == TFEND_BYTE) begin
      data = FEND_BYTE;
    end else if (esc_r && rx_byte == TFESC_BYTE) begin
      data = FESC_BYTE;
    end
    wr_data = data;
    if (byte_acc) begin
      if (drop_r) begin
        if (rx_byte == FEND_BYTE) begin
          len_nxt  = '0;
          esc_nxt  = 1'b0;
          drop_nxt = 1'b0;
          crc_nxt  = CRC_INIT;
        end
      end else if (rx_byte == FEND_BYTE) begin
        if (len_r != '0) begin
          if (32'(len_r) >= MIN_LEN) begin
            if (crc_r == {p1_r, p0_r}) begin
              counts_nxt.good = counts_r.good + 32'd1;
              start_nxt       = 1'b1;
              pay_nxt         = len_r - LEN_W'(2);
            end else begin
              counts_nxt.bad = counts_r.bad + 32'd1;
            end
          end
          len_nxt = '0;
          crc_nxt = CRC_INIT;
        end
        esc_nxt = 1'b0;
      end else if (rx_byte == FESC_BYTE) begin
        esc_nxt = 1'b1;
      end else begin
        esc_nxt = 1'b0;
        if (len_r < LEN_W'(FRAME_BYTES)) begin
          wr_en   = 1'b1;
          len_nxt = len_r + LEN_W'(1);
          p0_nxt  = data;
          p1_nxt  = p0_r;
          if (len_r >= LEN_W'(2)) begin
            crc_nxt = crc16_byte(crc_r, p1_r);
          end
        end else begin
          drop_nxt = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r    <= '0;
      esc_r    <= 1'b0;
      drop_r   <= 1'b0;
      crc_r    <= CRC_INIT;
      start_r  <= 1'b0;
      counts_r <= '0;
    end else begin
      len_r    <= len_nxt;
      esc_r    <= esc_nxt;
      drop_r   <= drop_nxt;
      crc_r    <= crc_nxt;
      start_r  <= start_nxt;
      counts_r <= counts_nxt;
    end
  end

  always_ff @(posedge clk) begin
    p0_r  <= p0_nxt;
    p1_r  <= p1_nxt;
    pay_r <= pay_nxt;
  end

  a_wr_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> len_r < LEN_W'(FRAME_BYTES))
    else $error("store write past frame end");

  a_start_clears_len: assert property (@(posedge clk) disable iff (!rst_n)
    start_r |-> len_r == '0 && crc_r == CRC_INIT)
    else $error("frame state not cleared at unpack start");

  a_drop_at_full: assert property (@(posedge clk) disable iff (!rst_n)
    drop_r |-> len_r == LEN_W'(FRAME_BYTES))
    else $error("drop state without a full frame");

endmodule

@@ hw/rtl/ssfr_unpack.sv @@
`timescale 1ns / 1ps

module ssfr_unpack import ssfr_pkg::*; #(
  parameter int FRAME_BYTES = 512,
  parameter int LEN_W       = $clog2(FRAME_BYTES + 1),
  parameter int ADDR_W      = $clog2(FRAME_BYTES)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [LEN_W-1:0]  pay,
  input  frame_counts_t     counts,
  output logic              busy,
  output logic              rd_en,
  output logic [ADDR_W-1:0] rd_addr,
  input  logic [7:0]        rd_data,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [11:0]       out_sample_a,
  output logic [11:0]       out_sample_b,
  output logic [11:0]       out_sample_c,
  output logic [11:0]       out_sample_d,
  output logic [2:0]        out_group_count,
  output logic              out_frame_last,
  output logic [31:0]       out_good_frames,
  output logic [31:0]       out_crc_failures
);

  unp_state_t       state_r, state_nxt;
  logic [7:0]       cnt_r, cnt_nxt;
  logic [8:0]       idx_r, idx_nxt;
  logic [LEN_W-1:0] off_r, off_nxt;
  logic [LEN_W-1:0] pay_r, pay_nxt;
  logic             two_r, two_nxt;
  logic [7:0]       b0_r, b0_nxt;
  logic [7:0]       b1_r, b1_nxt;
  logic [11:0]      samp_r [4];
  logic [11:0]      samp_nxt [4];
  logic [2:0]       grp_n_r, grp_n_nxt;
  logic             last_r, last_nxt;

  logic             out_valid_r, out_valid_nxt;
  logic [11:0]      out_samp_r [4];
  logic [11:0]      out_samp_nxt [4];
  logic [2:0]       out_count_r, out_count_nxt;
  logic             out_last_r, out_last_nxt;
  frame_counts_t    out_counts_r, out_counts_nxt;

  logic             more;
  logic             two;
  logic             out_free;
  logic [1:0]       slot_lo;
  logic [1:0]       slot_hi;

  assign more     = (idx_r < {1'b0, cnt_r}) &&
                    ({1'b0, off_r} + (LEN_W + 1)'(2) <= {1'b0, pay_r});
  assign two      = (idx_r + 9'd1) < {1'b0, cnt_r};
  assign out_free = !out_valid_r || out_ready;
  assign slot_lo  = {grp_n_r[1], 1'b0};
  assign slot_hi  = {grp_n_r[1], 1'b1};
  assign busy     = state_r != UNP_IDLE;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      UNP_IDLE:  if (start) state_nxt = UNP_CNT;
      UNP_CNT:   state_nxt = UNP_CNT_D;
      UNP_CNT_D: state_nxt = UNP_CHK;
      UNP_CHK: begin
        if (grp_n_r == GROUP_FULL) begin
          state_nxt = UNP_EMIT;
        end else if (more) begin
          state_nxt = UNP_B0;
        end else if (grp_n_r != '0) begin
          state_nxt = UNP_EMIT;
        end else begin
          state_nxt = UNP_IDLE;
        end
      end
      UNP_B0:    state_nxt = two_r ? UNP_B1 : UNP_CHK;
      UNP_B1:    state_nxt = UNP_B2;
      UNP_B2:    state_nxt = UNP_CHK;
      UNP_EMIT:  if (out_free) state_nxt = last_r ? UNP_IDLE : UNP_CHK;
      default:   state_nxt = UNP_IDLE;
    endcase
  end

  always_comb begin
    cnt_nxt        = cnt_r;
    idx_nxt        = idx_r;
    off_nxt        = off_r;
    pay_nxt        = pay_r;
    two_nxt        = two_r;
    b0_nxt         = b0_r;
    b1_nxt         = b1_r;
    samp_nxt       = samp_r;
    grp_n_nxt      = grp_n_r;
    last_nxt       = last_r;
    out_valid_nxt  = out_valid_r;
    out_samp_nxt   = out_samp_r;
    out_count_nxt  = out_count_r;
    out_last_nxt   = out_last_r;
    out_counts_nxt = out_counts_r;
    rd_en          = 1'b0;
    rd_addr        = off_r[ADDR_W-1:0];
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      UNP_IDLE: begin
        if (start) begin
          pay_nxt   = pay;
          grp_n_nxt = '0;
          for (int k = 0; k < 4; k++) samp_nxt[k] = '0;
        end
      end
      UNP_CNT: begin
        rd_en   = 1'b1;
        rd_addr = ADDR_W'(HEADER_BYTES);
      end
      UNP_CNT_D: begin
        cnt_nxt = rd_data;
        idx_nxt = '0;
        off_nxt = LEN_W'(HEADER_BYTES + 1);
      end
      UNP_CHK: begin
        if (grp_n_r == GROUP_FULL) begin
          last_nxt = !more;
        end else if (more) begin
          rd_en   = 1'b1;
          two_nxt = two;
        end else begin
          last_nxt = 1'b1;
        end
      end
      UNP_B0: begin
        b0_nxt = rd_data;
        if (two_r) begin
          rd_en   = 1'b1;
          rd_addr = off_r[ADDR_W-1:0] + ADDR_W'(1);
        end else begin
          samp_nxt[slot_lo] = {4'h0, rd_data};
          grp_n_nxt         = grp_n_r + 3'd1;
          idx_nxt           = idx_r + 9'd2;
          off_nxt           = off_r + LEN_W'(1);
        end
      end
      UNP_B1: begin
        b1_nxt  = rd_data;
        rd_en   = 1'b1;
        rd_addr = off_r[ADDR_W-1:0] + ADDR_W'(2);
      end
      UNP_B2: begin
        samp_nxt[slot_lo] = {b1_r[3:0], b0_r};
        samp_nxt[slot_hi] = {rd_data, b1_r[7:4]};
        grp_n_nxt         = grp_n_r + 3'd2;
        idx_nxt           = idx_r + 9'd2;
        off_nxt           = off_r + LEN_W'(3);
      end
      UNP_EMIT: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_samp_nxt   = samp_r;
          out_count_nxt  = grp_n_r;
          out_last_nxt   = last_r;
          out_counts_nxt = counts;
          grp_n_nxt      = '0;
          for (int k = 0; k < 4; k++) samp_nxt[k] = '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= UNP_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r        <= cnt_nxt;
    idx_r        <= idx_nxt;
    off_r        <= off_nxt;
    pay_r        <= pay_nxt;
    two_r        <= two_nxt;
    b0_r         <= b0_nxt;
    b1_r         <= b1_nxt;
    samp_r       <= samp_nxt;
    grp_n_r      <= grp_n_nxt;
    last_r       <= last_nxt;
    out_samp_r   <= out_samp_nxt;
    out_count_r  <= out_count_nxt;
    out_last_r   <= out_last_nxt;
    out_counts_r <= out_counts_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_sample_a     = out_samp_r[0];
  assign out_sample_b     = out_samp_r[1];
  assign out_sample_c     = out_samp_r[2];
  assign out_sample_d     = out_samp_r[3];
  assign out_group_count  = out_count_r;
  assign out_frame_last   = out_last_r;
  assign out_good_frames  = out_counts_r.good;
  assign out_crc_failures = out_counts_r.bad;

  a_start_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> state_r == UNP_IDLE)
    else $error("unpack started while busy");

  a_emit_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == UNP_EMIT |-> grp_n_r != '0 && grp_n_r <= GROUP_FULL)
    else $error("empty or oversized sample group");

  a_byte_read_issued: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == UNP_B0 |-> $past(rd_en))
    else $error("sample byte used without a read");

endmodule

@@ hw/rtl/slip_crc_sample_frame_receiver.sv @@
`timescale 1ns / 1ps

// SLIP frame receiver with CRC16 check and 12-bit sample unpacking.
// Input channel: one link byte per word (in_valid/in_ready/in_rx_byte).
// Result channel: one group of up to four samples per word, with the frame's
// last-group flag and the good and failed frame counts after that frame.
// Bytes are de-escaped and written to the frame store; the CRC runs on the
// fly two bytes behind, so in_ready stays high between frames. After the END
// of a good frame the unpack sequencer walks the store through its single
// read port: it starts and fetches the count byte, reads each sample pair in
// states CHK, B0, B1 and B2 (CHK and B0 for a lone sample) and emits each
// group through CHK and EMIT. in_ready is low for that walk, from the cycle after END.
// The output register lets the last group wait while new bytes are taken.
// When the receiver stalls, the walk holds at the next group until the
// output register frees.
// Reset clears the frame length, escape, drop state and both counters;
// the frame store needs no clearing.
module slip_crc_sample_frame_receiver import ssfr_pkg::*; #(
  parameter int FRAME_BYTES = 512
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [11:0] out_sample_a,
  output logic [11:0] out_sample_b,
  output logic [11:0] out_sample_c,
  output logic [11:0] out_sample_d,
  output logic [2:0]  out_group_count,
  output logic        out_frame_last,
  output logic [31:0] out_good_frames,
  output logic [31:0] out_crc_failures
);

  localparam int LEN_W  = $clog2(FRAME_BYTES + 1);
  localparam int ADDR_W = $clog2(FRAME_BYTES);

  logic              byte_acc;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [7:0]        wr_data;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic [7:0]        rd_data;
  logic              start;
  logic [LEN_W-1:0]  pay;
  frame_counts_t     counts;
  logic              busy;

  assign in_ready = !busy && !start;
  assign byte_acc = in_valid && in_ready;

  ssfr_ram #(
    .WIDTH (8),
    .DEPTH (FRAME_BYTES)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  ssfr_deframe #(
    .FRAME_BYTES (FRAME_BYTES),
    .LEN_W       (LEN_W),
    .ADDR_W      (ADDR_W)
  ) u_deframe (
    .clk      (clk),
    .rst_n    (rst_n),
    .byte_acc (byte_acc),
    .rx_byte  (in_rx_byte),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .start_r  (start),
    .pay_r    (pay),
    .counts_r (counts)
  );

  ssfr_unpack #(
    .FRAME_BYTES (FRAME_BYTES),
    .LEN_W       (LEN_W),
    .ADDR_W      (ADDR_W)
  ) u_unpack (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .pay              (pay),
    .counts           (counts),
    .busy             (busy),
    .rd_en            (rd_en),
    .rd_addr          (rd_addr),
    .rd_data          (rd_data),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_sample_a     (out_sample_a),
    .out_sample_b     (out_sample_b),
    .out_sample_c     (out_sample_c),
    .out_sample_d     (out_sample_d),
    .out_group_count  (out_group_count),
    .out_frame_last   (out_frame_last),
    .out_good_frames  (out_good_frames),
    .out_crc_failures (out_crc_failures)
  );

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top import ssfr_pkg::*; ();

  localparam int FRAME_BYTES   = 512;
  localparam int CYCLE_LIMIT   = 2000000;
  localparam int DRAIN_CYCLES  = 600;
  localparam int PRESSURE_HOLD = 600;
  localparam int LINK_WORDS    = 370;

  typedef logic [7:0] octet_q_t[$];

  typedef struct packed {
    logic [7:0] b;
    logic       hold;
  } link_word_t;

  typedef struct packed {
    logic [3:0][11:0] smp;
    logic [2:0]       n;
    logic             last;
    logic [31:0]      good;
    logic [31:0]      bad;
  } sample_group_t;

  typedef enum int {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_rx_byte = 8'h00;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [11:0] out_sample_a;
  logic [11:0] out_sample_b;
  logic [11:0] out_sample_c;
  logic [11:0] out_sample_d;
  logic [2:0]  out_group_count;
  logic        out_frame_last;
  logic [31:0] out_good_frames;
  logic [31:0] out_crc_failures;

  link_word_t    link_words[$];
  sample_group_t pending_groups[$];

  int         total_words = 1;
  int         words_taken = 0;
  int         mismatch_count = 0;
  int         cycle_count = 0;
  int         hold_left = 0;
  logic       hold_kick = 1'b0;
  logic       cur_hold = 1'b0;
  idle_mode_t idle_mode = IDLE_NONE;

  logic [7:0]  shadow_store [FRAME_BYTES];
  int          shadow_len = 0;
  logic        shadow_esc = 1'b0;
  logic        shadow_drop = 1'b0;
  logic [31:0] shadow_good = '0;
  logic [31:0] shadow_bad = '0;

  slip_crc_sample_frame_receiver #(
    .FRAME_BYTES(FRAME_BYTES)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_rx_byte(in_rx_byte),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_sample_a(out_sample_a),
    .out_sample_b(out_sample_b),
    .out_sample_c(out_sample_c),
    .out_sample_d(out_sample_d),
    .out_group_count(out_group_count),
    .out_frame_last(out_frame_last),
    .out_good_frames(out_good_frames),
    .out_crc_failures(out_crc_failures)
  );

  always #2 clk = ~clk;

  function automatic logic [15:0] crc_ccitt_step(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    repeat (8) c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    return c;
  endfunction

  function automatic int sender_gap_pct(input idle_mode_t m);
    case (m)
      IDLE_SENDER: return 49;
      IDLE_BOTH:   return 16;
      default:     return 0;
    endcase
  endfunction

  function automatic int receiver_stall_pct(input idle_mode_t m);
    case (m)
      IDLE_RECEIVER: return 49;
      IDLE_BOTH:     return 16;
      default:       return 0;
    endcase
  endfunction

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= 100) $display("%0t ns  mismatch: %s", $time, msg);
  endtask

  task automatic finish_slip_frame();
    int           pay;
    int           off;
    int           cnt;
    int           n;
    logic [15:0]  crc;
    logic [7:0]   b0;
    logic [7:0]   b1;
    logic [7:0]   b2;
    logic         two;
    logic [11:0]  samples[$];
    sample_group_t g;
    if (shadow_len < MIN_LEN) return;
    pay = shadow_len - 2;
    crc = CRC_INIT;
    for (int i = 0; i < pay; i++) crc = crc_ccitt_step(crc, shadow_store[i]);
    if (crc != {shadow_store[pay], shadow_store[pay + 1]}) begin
      shadow_bad++;
      return;
    end
    shadow_good++;
    cnt = shadow_store[HEADER_BYTES];
    off = HEADER_BYTES + 1;
    for (int i = 0; i < cnt; i += 2) begin
      two = (i + 1 < cnt);
      if (off + 2 > pay) break;
      b0 = shadow_store[off];
      b1 = 8'h00;
      b2 = 8'h00;
      off++;
      if (two) begin
        b1 = shadow_store[off];
        b2 = shadow_store[off + 1];
        off += 2;
      end
      samples.push_back({b1[3:0], b0});
      if (two) samples.push_back({b2, b1[7:4]});
    end
    while (samples.size() != 0) begin
      g = '0;
      n = 0;
      while (n < GROUP_FULL && samples.size() != 0) begin
        g.smp[n] = samples.pop_front();
        n++;
      end
      g.n = 3'(n);
      g.last = (samples.size() == 0);
      g.good = shadow_good;
      g.bad = shadow_bad;
      pending_groups.push_back(g);
    end
  endtask

  task automatic absorb_link_byte(input logic [7:0] b);
    logic [7:0] d;
    d = b;
    if (shadow_drop) begin
      if (d == FEND_BYTE) begin
        shadow_len = 0;
        shadow_esc = 1'b0;
        shadow_drop = 1'b0;
      end
    end else if (d == FEND_BYTE) begin
      if (shadow_len > 0) begin
        finish_slip_frame();
        shadow_len = 0;
      end
      shadow_esc = 1'b0;
    end else if (d == FESC_BYTE) begin
      shadow_esc = 1'b1;
    end else begin
      if (shadow_esc) begin
        if (d == TFEND_BYTE) d = FEND_BYTE;
        else if (d == TFESC_BYTE) d = FESC_BYTE;
        shadow_esc = 1'b0;
      end
      if (shadow_len < FRAME_BYTES) begin
        shadow_store[shadow_len] = d;
        shadow_len++;
      end else begin
        shadow_drop = 1'b1;
      end
    end
  endtask

  task automatic check_group();
    sample_group_t want;
    sample_group_t got;
    got.smp = {out_sample_d, out_sample_c, out_sample_b, out_sample_a};
    got.n = out_group_count;
    got.last = out_frame_last;
    got.good = out_good_frames;
    got.bad = out_crc_failures;
    if (pending_groups.size() == 0) begin
      report_mismatch($sformatf("group with none expected: a=%03h count=%0d last=%0d",
                                got.smp[0], got.n, got.last));
      return;
    end
    want = pending_groups.pop_front();
    for (int k = 0; k < 4; k++) begin
      if (got.smp[k] !== want.smp[k])
        report_mismatch($sformatf("sample %0d: got %03h, want %03h", k, got.smp[k],
                                  want.smp[k]));
    end
    if (got.n !== want.n)
      report_mismatch($sformatf("group_count: got %0d, want %0d", got.n, want.n));
    if (got.last !== want.last)
      report_mismatch($sformatf("frame_last: got %0d, want %0d", got.last, want.last));
    if (got.good !== want.good)
      report_mismatch($sformatf("good_frames: got %0d, want %0d", got.good, want.good));
    if (got.bad !== want.bad)
      report_mismatch($sformatf("crc_failures: got %0d, want %0d", got.bad, want.bad));
  endtask

  function automatic logic [7:0] random_link_byte();
    case ($urandom_range(15))
      0:       return FEND_BYTE;
      1:       return FESC_BYTE;
      2:       return TFEND_BYTE;
      3:       return TFESC_BYTE;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic int data_bytes_for(input int cnt);
    int full;
    int r;
    full = 3 * ((cnt + 1) / 2);
    r = $urandom_range(99);
    if (r < 70) return full;
    if (r < 85) return (full >= 3) ? full - $urandom_range(1, 3) : full;
    return full + $urandom_range(1, 4);
  endfunction

  task automatic push_word(input logic [7:0] b, input logic hold);
    link_word_t w;
    w.b = b;
    w.hold = hold;
    link_words.push_back(w);
  endtask

  task automatic build_sample_body(output octet_q_t body, input int cnt, input int data_len);
    body = {};
    repeat (HEADER_BYTES) body.push_back(random_link_byte());
    body.push_back(8'(cnt));
    repeat (data_len) body.push_back(random_link_byte());
  endtask

  task automatic append_crc(inout octet_q_t body, input logic corrupt);
    logic [15:0] crc;
    crc = CRC_INIT;
    foreach (body[i]) crc = crc_ccitt_step(crc, body[i]);
    if (corrupt) crc ^= 16'h0001 << $urandom_range(15);
    body.push_back(crc[15:8]);
    body.push_back(crc[7:0]);
  endtask

  task automatic send_frame(input octet_q_t body, input logic esc_tail, input logic hold);
    foreach (body[i]) begin
      if (body[i] == FEND_BYTE) begin
        push_word(FESC_BYTE, 1'b0);
        push_word(TFEND_BYTE, 1'b0);
      end else if (body[i] == FESC_BYTE) begin
        push_word(FESC_BYTE, 1'b0);
        push_word(TFESC_BYTE, 1'b0);
      end else begin
        if (body[i] != TFEND_BYTE && body[i] != TFESC_BYTE && $urandom_range(11) == 0)
          push_word(FESC_BYTE, 1'b0);
        push_word(body[i], 1'b0);
      end
    end
    if (esc_tail) push_word(FESC_BYTE, 1'b0);
    push_word(FEND_BYTE, hold);
  endtask

  task automatic queue_random_frame();
    octet_q_t body;
    int pick;
    int cnt;
    int len;
    pick = $urandom_range(99);
    if (pick < 63) begin
      cnt = ($urandom_range(4) != 0) ? $urandom_range(1, 12) : $urandom_range(13, 60);
      build_sample_body(body, cnt, data_bytes_for(cnt));
      append_crc(body, pick >= 55);
      send_frame(body, 1'b0, 1'b0);
    end else if (pick < 68) begin
      build_sample_body(body, 0, $urandom_range(0, 6));
      append_crc(body, 1'b0);
      send_frame(body, 1'b0, 1'b0);
    end else if (pick < 73) begin
      body = {};
      len = $urandom_range(1, 4);
      repeat (len) body.push_back(random_link_byte());
      send_frame(body, 1'b0, 1'b0);
    end else if (pick < 78) begin
      push_word(FEND_BYTE, 1'b0);
    end else if (pick < 83) begin
      cnt = $urandom_range(1, 8);
      build_sample_body(body, cnt, data_bytes_for(cnt));
      append_crc(body, 1'b0);
      send_frame(body, 1'b1, 1'b0);
    end else if (pick < 88) begin
      body = {};
      len = $urandom_range(3, 4);
      repeat (len) body.push_back(random_link_byte());
      append_crc(body, 1'b0);
      send_frame(body, 1'b0, 1'b0);
    end else if (pick < 94) begin
      len = $urandom_range(1, 10);
      repeat (len) push_word(random_link_byte(), 1'b0);
      push_word(FEND_BYTE, 1'b0);
    end else begin
      build_sample_body(body, $urandom_range(0, 255), $urandom_range(0, 24));
      append_crc(body, 1'b0);
      send_frame(body, 1'b0, 1'b0);
    end
  endtask

  always @(posedge clk) begin : drive_link
    link_word_t nxt;
    logic       fire;
    int         q;
    if (!rst_n) begin
      in_valid <= 1'b0;
      hold_kick <= 1'b0;
    end else begin
      fire = in_valid && in_ready;
      if (fire) absorb_link_byte(in_rx_byte);
      if (!in_valid || fire) begin
        if (link_words.size() != 0 && $urandom_range(99) >= sender_gap_pct(idle_mode)) begin
          nxt = link_words.pop_front();
          in_valid <= 1'b1;
          in_rx_byte <= nxt.b;
          cur_hold <= nxt.hold;
        end else begin
          in_valid <= 1'b0;
        end
      end
      hold_kick <= fire && cur_hold;
      if (fire) words_taken <= words_taken + 1;
      q = (words_taken * 4) / total_words;
      if (q > 3) q = 3;
      idle_mode <= idle_mode_t'(q);
    end
  end

  always @(posedge clk) begin
    if (!rst_n) hold_left <= 0;
    else if (hold_kick) hold_left <= PRESSURE_HOLD;
    else if (hold_left != 0) hold_left <= hold_left - 1;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) check_group();
      out_ready <= (hold_left == 0) && ($urandom_range(99) >= receiver_stall_pct(idle_mode));
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin : stimulus
    octet_q_t body;

    push_word(FEND_BYTE, 1'b0);
    push_word(FESC_BYTE, 1'b0);
    push_word(FEND_BYTE, 1'b0);
    body = {8'h11, 8'h22};
    send_frame(body, 1'b0, 1'b0);
    body = {8'h00, 8'hFF, 8'h80};
    append_crc(body, 1'b0);
    send_frame(body, 1'b0, 1'b0);
    body = {8'h00, 8'hFF, FEND_BYTE, FESC_BYTE, 8'd4,
            8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00};
    append_crc(body, 1'b0);
    send_frame(body, 1'b0, 1'b0);

    build_sample_body(body, 14, 21);
    append_crc(body, 1'b0);
    send_frame(body, 1'b0, 1'b1);
    while (link_words.size() < LINK_WORDS) begin
      queue_random_frame();
    end
    total_words = link_words.size();

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    while (words_taken != total_words) @(posedge clk);
    while (pending_groups.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
